FILE: hw/rtl/mwm_pkg.sv
// mwm_pkg: shared types and constants of the maze wall mapper.
// Used by mwm_ctrl, mwm_dp and the top level; depends on nothing.
`default_nettype none

package mwm_pkg;

	// configuration register indexes
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 16;
	localparam logic [CfgIdxW-1:0] CFG_CELL_LENGTH = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_FRONT_THRESH = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_RIGHT_THRESH = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_LEFT_THRESH = 2'd3;

	localparam logic [15:0] CELL_LENGTH_RST = 16'd1000;
	localparam logic [11:0] THRESH_RST = 12'd2000;

	// absolute directions, also the wall bit positions
	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	// turns relative to heading (quarter turns clockwise)
	localparam logic [1:0] ROT_FRONT = 2'd0;
	localparam logic [1:0] ROT_RIGHT = 2'd1;
	localparam logic [1:0] ROT_BACK = 2'd2;
	localparam logic [1:0] ROT_LEFT = 2'd3;

	// move codes
	localparam logic [1:0] MOVE_RIGHT = 2'd0;
	localparam logic [1:0] MOVE_FORWARD = 2'd1;
	localparam logic [1:0] MOVE_LEFT = 2'd2;
	localparam logic [1:0] MOVE_AROUND = 2'd3;

	// serial divider
	localparam int DIV_STEPS = 16;
	localparam int DivCntW = $clog2(DIV_STEPS);

	typedef struct packed {
		logic       clr;        // write zero at clear pointer, advance it
		logic       capture;    // latch input item
		logic       div_step;   // one restoring divide step
		logic       update_pos; // step position on new cell count
		logic       rd_nb;      // read neighbor of dir instead of current cell
		logic       wr_here;    // merge walls into current cell
		logic       wr_nb;      // merge opposite wall into neighbor of dir
		logic [1:0] dir;        // direction under work
		logic       load_out;   // load result register
	} mwm_cmd_t;

	typedef struct packed {
		logic clr_done;  // clear pointer at last entry
		logic nb_needed; // wall toward dir and that neighbor exists
	} mwm_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mwm_ram.sv
// mwm_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`default_nettype none

module mwm_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/mwm_ctrl.sv
// mwm_ctrl: sequencer of the wall mapper (clear pass, divide, map updates).
// Depends on mwm_pkg; drives mwm_dp through mwm_cmd_t.
`default_nettype none

module mwm_ctrl
	import mwm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	input  wire mwm_sts_t  sts,
	output mwm_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_POS,
		ST_RD_HERE,
		ST_WR_HERE,
		ST_NB,
		ST_NB_WR
	} state_t;

	state_t state_q;
	logic [DivCntW-1:0] cnt_q;
	logic [1:0] dir_q;
	logic out_valid_q;
	logic done_q; // result ready, waiting for the output register

	wire logic accept = in_valid && (state_q == ST_IDLE) && !done_q;
	wire logic out_free = !out_valid_q || !out_stall;

	assign in_stall = (state_q != ST_IDLE) || done_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.dir = dir_q;
		case (state_q)
			ST_CLEAR: cmd.clr = 1'b1;
			ST_IDLE: begin
				cmd.capture = accept;
				cmd.load_out = done_q && out_free;
			end
			ST_DIV: cmd.div_step = 1'b1;
			ST_POS: cmd.update_pos = 1'b1;
			ST_RD_HERE: ;
			ST_WR_HERE: cmd.wr_here = 1'b1;
			ST_NB: cmd.rd_nb = 1'b1;
			ST_NB_WR: cmd.wr_nb = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			dir_q <= DIR_N;
			out_valid_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (done_q) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							done_q <= 1'b0;
						end
					end else if (accept) begin
						cnt_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DivCntW'(DIV_STEPS - 1)) begin
						state_q <= ST_POS;
					end
				end
				ST_POS: state_q <= ST_RD_HERE;
				ST_RD_HERE: state_q <= ST_WR_HERE;
				ST_WR_HERE: begin
					dir_q <= DIR_N;
					state_q <= ST_NB;
				end
				ST_NB: begin
					if (sts.nb_needed) begin
						state_q <= ST_NB_WR;
					end else if (dir_q == DIR_W) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						dir_q <= dir_q + 1'b1;
					end
				end
				ST_NB_WR: begin
					if (dir_q == DIR_W) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						dir_q <= dir_q + 1'b1;
						state_q <= ST_NB;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/mwm_dp.sv
// mwm_dp: datapath of the wall mapper: config registers, serial divider,
// position, wall map RAM and result register. Depends on mwm_pkg, mwm_ram.
`default_nettype none

module mwm_dp
	import mwm_pkg::*;
#(
	parameter int MAZE_WIDTH = 16,
	parameter int MAZE_HEIGHT = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	input  wire logic [15:0]         enc_left,
	input  wire logic [15:0]         enc_right,
	input  wire logic [11:0]         sens_left_front,
	input  wire logic [11:0]         sens_right_front,
	input  wire logic [11:0]         sens_right_side,
	input  wire logic [11:0]         sens_left_side,
	input  wire logic [1:0]          heading,
	input  wire mwm_cmd_t            cmd,
	output mwm_sts_t                 sts,
	output logic [1:0]               move,
	output logic [3:0]               cell_x,
	output logic [3:0]               cell_y,
	output logic [3:0]               cell_walls
);

	localparam int Depth = MAZE_WIDTH * MAZE_HEIGHT;
	localparam int AW = $clog2(Depth);
	localparam int PW = $clog2(MAZE_WIDTH);
	localparam int PH = $clog2(MAZE_HEIGHT);
	localparam logic [PW-1:0] XMax = PW'(MAZE_WIDTH - 1);
	localparam logic [PH-1:0] YMax = PH'(MAZE_HEIGHT - 1);
	localparam logic [AW-1:0] RowStride = AW'(MAZE_WIDTH);
	localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

	// config
	logic [15:0] cell_length_q;
	logic [11:0] front_thr_q, right_thr_q, left_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_length_q <= CELL_LENGTH_RST;
			front_thr_q <= THRESH_RST;
			right_thr_q <= THRESH_RST;
			left_thr_q <= THRESH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CELL_LENGTH: cell_length_q <= cfg_data;
				CFG_FRONT_THRESH: front_thr_q <= cfg_data[11:0];
				CFG_RIGHT_THRESH: right_thr_q <= cfg_data[11:0];
				CFG_LEFT_THRESH: left_thr_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// item capture: halved encoder sum and absolute sensed walls
	logic [16:0] enc_sum;
	logic [1:0] dir_front, dir_right, dir_left;
	logic [3:0] sensed;

	assign enc_sum = 17'(enc_left) + 17'(enc_right);
	assign dir_front = heading + ROT_FRONT;
	assign dir_right = heading + ROT_RIGHT;
	assign dir_left = heading + ROT_LEFT;

	always_comb begin
		sensed = '0;
		if (sens_left_front > front_thr_q && sens_right_front > front_thr_q) begin
			sensed = sensed | (4'd1 << dir_front);
		end
		if (sens_right_side > right_thr_q) begin
			sensed = sensed | (4'd1 << dir_right);
		end
		if (sens_left_side > left_thr_q) begin
			sensed = sensed | (4'd1 << dir_left);
		end
	end

	logic [15:0] quo_q; // dividend shifting out, quotient shifting in
	logic [15:0] rem_q;
	logic [1:0] heading_q;
	logic [3:0] wall_q;
	logic [16:0] trial;
	logic trial_ok;

	assign trial = {rem_q, quo_q[15]};
	assign trial_ok = trial >= {1'b0, cell_length_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			quo_q <= enc_sum[16:1];
			rem_q <= '0;
			heading_q <= heading;
			wall_q <= sensed;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[14:0], trial_ok};
			rem_q <= trial_ok ? 16'(trial - {1'b0, cell_length_q}) : trial[15:0];
		end
	end

	// position and last cell count
	logic [PW-1:0] pos_x_q;
	logic [PH-1:0] pos_y_q;
	logic [15:0] last_count_q;
	logic [15:0] count;

	assign count = (cell_length_q == '0) ? '0 : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			last_count_q <= '0;
		end else if (cmd.update_pos && count > last_count_q) begin
			last_count_q <= count;
			case (heading_q)
				DIR_N: if (pos_y_q < YMax) pos_y_q <= pos_y_q + 1'b1;
				DIR_E: if (pos_x_q < XMax) pos_x_q <= pos_x_q + 1'b1;
				DIR_S: if (pos_y_q != '0) pos_y_q <= pos_y_q - 1'b1;
				DIR_W: if (pos_x_q != '0) pos_x_q <= pos_x_q - 1'b1;
				default: ;
			endcase
		end
	end

	// addresses
	logic [AW-1:0] here, nb_addr;
	logic nb_exists;

	assign here = AW'(pos_y_q) * RowStride + AW'(pos_x_q);

	always_comb begin
		case (cmd.dir)
			DIR_N: begin
				nb_addr = here + RowStride;
				nb_exists = pos_y_q < YMax;
			end
			DIR_E: begin
				nb_addr = here + 1'b1;
				nb_exists = pos_x_q < XMax;
			end
			DIR_S: begin
				nb_addr = here - RowStride;
				nb_exists = pos_y_q != '0;
			end
			DIR_W: begin
				nb_addr = here - 1'b1;
				nb_exists = pos_x_q != '0;
			end
			default: begin
				nb_addr = here;
				nb_exists = 1'b0;
			end
		endcase
	end

	assign sts.nb_needed = wall_q[cmd.dir] && nb_exists;

	// clear pointer for the pass after reset
	logic [AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr && clr_q != LastAddr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign sts.clr_done = clr_q == LastAddr;

	// wall map
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [3:0] ram_wdata, ram_rdata;
	logic [1:0] opp_dir;

	assign opp_dir = cmd.dir + ROT_BACK;
	assign ram_raddr = cmd.rd_nb ? nb_addr : here;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = here;
		ram_wdata = ram_rdata | wall_q;
		if (cmd.clr) begin
			ram_we = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (cmd.wr_here) begin
			ram_we = 1'b1;
		end else if (cmd.wr_nb) begin
			ram_we = 1'b1;
			ram_waddr = nb_addr;
			ram_wdata = ram_rdata | (4'd1 << opp_dir);
		end
	end

	mwm_ram #(
		.WIDTH(4),
		.DEPTH(Depth)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// merged walls of the current cell; neighbor writes never touch it
	logic [3:0] walls_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_here) begin
			walls_q <= ram_rdata | wall_q;
		end
	end

	// result register
	logic [1:0] hd_front, hd_right, hd_left;
	logic [1:0] move_d;
	logic [PW+3:0] x_ext;
	logic [PH+3:0] y_ext;

	assign hd_front = heading_q + ROT_FRONT;
	assign hd_right = heading_q + ROT_RIGHT;
	assign hd_left = heading_q + ROT_LEFT;
	assign x_ext = {4'd0, pos_x_q};
	assign y_ext = {4'd0, pos_y_q};

	always_comb begin
		if (!walls_q[hd_right]) move_d = MOVE_RIGHT;
		else if (!walls_q[hd_front]) move_d = MOVE_FORWARD;
		else if (!walls_q[hd_left]) move_d = MOVE_LEFT;
		else move_d = MOVE_AROUND;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			move <= move_d;
			cell_x <= x_ext[3:0];
			cell_y <= y_ext[3:0];
			cell_walls <= walls_q;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/maze_wall_mapper_right_hand.sv
// maze_wall_mapper_right_hand: top level of the micromouse wall mapper.
// Depends on mwm_pkg, mwm_ctrl, mwm_dp (and mwm_ram inside mwm_dp).
//
// One control tick in, one result out. The block takes a tick (encoder
// counts, four sensor readings, heading), halves the encoder sum and
// divides it by cell_length with a restoring divider, one quotient bit per
// clock. If that cell count is above the last one stored, the position
// steps one cell along the heading, held at the maze edges. Sensed walls
// are OR-merged into the current cell of the wall map and, opposite-facing,
// into the neighbor behind each sensed wall where it exists; the map is a
// single MAZE_WIDTH*MAZE_HEIGHT x 4 RAM with one write and one registered
// read port, so every merge is a read then a write. The steps run in
// order: divider, position step, current-cell merge, neighbor merges. The
// result carries the right-hand-rule move, the cell (low 4 bits of each
// coordinate) and its walls. A new tick is taken the cycle after its
// predecessor's result goes into the output register; the output register
// holds a result until transferred while the next tick is already taken.
// After reset the map is cleared one entry per clock, all MAZE_WIDTH *
// MAZE_HEIGHT entries (256 at the defaults), during which in_stall is high.
// Configuration writes are always ready; write them only while idle.
`default_nettype none

module maze_wall_mapper_right_hand
	import mwm_pkg::*;
#(
	parameter int MAZE_WIDTH = 16,
	parameter int MAZE_HEIGHT = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration write
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	// input ticks
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [15:0]         enc_left,
	input  wire logic [15:0]         enc_right,
	input  wire logic [11:0]         sens_left_front,
	input  wire logic [11:0]         sens_right_front,
	input  wire logic [11:0]         sens_right_side,
	input  wire logic [11:0]         sens_left_side,
	input  wire logic [1:0]          heading,
	// results
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [1:0]               move,
	output logic [3:0]               cell_x,
	output logic [3:0]               cell_y,
	output logic [3:0]               cell_walls
);

	mwm_cmd_t cmd;
	mwm_sts_t sts;

	// registers take any write, so ready is tied high
	assign cfg_ready = 1'b1;

	mwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mwm_dp #(
		.MAZE_WIDTH (MAZE_WIDTH),
		.MAZE_HEIGHT(MAZE_HEIGHT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.enc_left        (enc_left),
		.enc_right       (enc_right),
		.sens_left_front (sens_left_front),
		.sens_right_front(sens_right_front),
		.sens_right_side (sens_right_side),
		.sens_left_side  (sens_left_side),
		.heading         (heading),
		.cmd             (cmd),
		.sts             (sts),
		.move            (move),
		.cell_x          (cell_x),
		.cell_y          (cell_y),
		.cell_walls      (cell_walls)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/mwm_chk.sv
// mwm_chk: port-level checks of the wall mapper, bound to the top level.
// Depends on maze_wall_mapper_right_hand's port list only.
`default_nettype none

module mwm_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] move,
	input wire logic [3:0] cell_x,
	input wire logic [3:0] cell_y,
	input wire logic [3:0] cell_walls
);

	// one tick at a time: stall right after a transfer in
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after transfer");

	// a result takes many cycles, never shows right after a transfer in
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !$rose(out_valid))
		else $error("result right after input transfer");

	// the block is ready again when a result appears
	a_ready_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("input still stalled when result appears");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable({move, cell_x, cell_y, cell_walls})))
		else $error("stalled result changed");

endmodule

bind maze_wall_mapper_right_hand mwm_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.move      (move),
	.cell_x    (cell_x),
	.cell_y    (cell_y),
	.cell_walls(cell_walls)
);

`default_nettype wire

FILE: tb/tb_maze_wall_mapper_right_hand.sv
// tb_maze_wall_mapper_right_hand: self-checking bench for the right-hand-rule maze wall mapper.
// Depends on mwm_pkg and maze_wall_mapper_right_hand; tracks position, cell count and wall
// map in its own model and checks every result transfer against it.
`default_nettype none

module tb_maze_wall_mapper_right_hand
	import mwm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAZE_W = 16;
	localparam int MAZE_H = 16;
	// Slowest correct run is about 800 ticks, each with its work, a sender gap
	// and a receiver stall, plus the map clear, the long hold and the idle waits.
	localparam int CYCLE_LIMIT = 400000;
	// worst-case tick latency plus margin, used before config writes and at the end
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [15:0] enc_left;
		logic [15:0] enc_right;
		logic [11:0] sens_left_front;
		logic [11:0] sens_right_front;
		logic [11:0] sens_right_side;
		logic [11:0] sens_left_side;
		logic [1:0]  heading;
	} tick_t;

	typedef struct packed {
		logic [1:0] move;
		logic [3:0] cell_x;
		logic [3:0] cell_y;
		logic [3:0] cell_walls;
	} cell_report_t;

	// ------------------------------------------------------------------
	// DUT signals, inputs driven to known values from time zero
	// ------------------------------------------------------------------
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = CFG_CELL_LENGTH;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [15:0]         enc_left = '0;
	logic [15:0]         enc_right = '0;
	logic [11:0]         sens_left_front = '0;
	logic [11:0]         sens_right_front = '0;
	logic [11:0]         sens_right_side = '0;
	logic [11:0]         sens_left_side = '0;
	logic [1:0]          heading = DIR_N;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          move;
	logic [3:0]          cell_x;
	logic [3:0]          cell_y;
	logic [3:0]          cell_walls;

	maze_wall_mapper_right_hand u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.enc_left         (enc_left),
		.enc_right        (enc_right),
		.sens_left_front  (sens_left_front),
		.sens_right_front (sens_right_front),
		.sens_right_side  (sens_right_side),
		.sens_left_side   (sens_left_side),
		.heading          (heading),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.move             (move),
		.cell_x           (cell_x),
		.cell_y           (cell_y),
		.cell_walls       (cell_walls)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Mouse tracking model: own copy of the map, position and config
	// ------------------------------------------------------------------
	logic [3:0]   map_walls [MAZE_W*MAZE_H];
	int           mouse_x = 0;
	int           mouse_y = 0;
	int           cells_done = 0;   // last travelled-cell count
	int           cell_len = int'(CELL_LENGTH_RST);
	int           front_thr = int'(THRESH_RST);
	int           right_thr = int'(THRESH_RST);
	int           left_thr = int'(THRESH_RST);

	cell_report_t predicted_reports [$];
	int           mismatches = 0;
	int           cycle_count = 0;
	bit           idle_on = 1'b1;   // random gaps and stalls enabled
	int           hold_len = 0;     // request for one long receiver hold

	initial begin
		foreach (map_walls[i])
			map_walls[i] = 4'h0;
	end

	// absolute wall bit of the side at quarter turn rot from heading
	function automatic logic [3:0] side_bit(logic [1:0] hdg, logic [1:0] rot);
		logic [1:0] dir;
		dir = hdg + rot;
		return 4'b0001 << dir;
	endfunction

	// one accepted tick: step, merge walls, pick the move, queue the report
	task automatic track_mouse(input tick_t t);
		int           avg;
		int           cells;
		int           here;
		logic [3:0]   seen;
		logic [3:0]   w;
		cell_report_t rep;
		avg = (int'(t.enc_left) + int'(t.enc_right)) >> 1;
		cells = (cell_len == 0) ? 0 : (avg / cell_len) & 16'hFFFF;
		if (cells > cells_done) begin
			case (t.heading)
				DIR_N: if (mouse_y < MAZE_H - 1) mouse_y++;
				DIR_E: if (mouse_x < MAZE_W - 1) mouse_x++;
				DIR_S: if (mouse_y > 0) mouse_y--;
				default: if (mouse_x > 0) mouse_x--;
			endcase
			cells_done = cells;
		end

		// front needs both front sensors; sides use their own thresholds
		seen = 4'h0;
		if (int'(t.sens_left_front) > front_thr && int'(t.sens_right_front) > front_thr)
			seen |= side_bit(t.heading, ROT_FRONT);
		if (int'(t.sens_right_side) > right_thr)
			seen |= side_bit(t.heading, ROT_RIGHT);
		if (int'(t.sens_left_side) > left_thr)
			seen |= side_bit(t.heading, ROT_LEFT);

		// merge here, and the facing wall into each neighbor on a seen side inside the maze
		here = mouse_y * MAZE_W + mouse_x;
		map_walls[here] |= seen;
		if (seen[DIR_N] && mouse_y < MAZE_H - 1)
			map_walls[here + MAZE_W] |= 4'b0001 << DIR_S;
		if (seen[DIR_E] && mouse_x < MAZE_W - 1)
			map_walls[here + 1] |= 4'b0001 << DIR_W;
		if (seen[DIR_S] && mouse_y > 0)
			map_walls[here - MAZE_W] |= 4'b0001 << DIR_N;
		if (seen[DIR_W] && mouse_x > 0)
			map_walls[here - 1] |= 4'b0001 << DIR_E;

		// right-hand rule
		w = map_walls[here];
		if ((w & side_bit(t.heading, ROT_RIGHT)) == 4'h0)
			rep.move = MOVE_RIGHT;
		else if ((w & side_bit(t.heading, ROT_FRONT)) == 4'h0)
			rep.move = MOVE_FORWARD;
		else if ((w & side_bit(t.heading, ROT_LEFT)) == 4'h0)
			rep.move = MOVE_LEFT;
		else
			rep.move = MOVE_AROUND;
		rep.cell_x = 4'(mouse_x);
		rep.cell_y = 4'(mouse_y);
		rep.cell_walls = w;
		predicted_reports.push_back(rep);
	endtask

	// ------------------------------------------------------------------
	// Tick builders
	// ------------------------------------------------------------------
	function automatic tick_t mk_tick(int el, int er, int lf, int rf, int rs, int ls,
			logic [1:0] hdg);
		tick_t t;
		t.enc_left = 16'(el);
		t.enc_right = 16'(er);
		t.sens_left_front = 12'(lf);
		t.sens_right_front = 12'(rf);
		t.sens_right_side = 12'(rs);
		t.sens_left_side = 12'(ls);
		t.heading = hdg;
		return t;
	endfunction

	// reading spread around a threshold: often exactly at it or just above it
	function automatic logic [11:0] reading_near(int thr);
		case ($urandom_range(0, 3))
			0: return 12'($urandom_range(0, 4095));
			1: return 12'((thr < 4095) ? $urandom_range(thr + 1, 4095) : 4095);
			2: return 12'($urandom_range(0, thr));
			default: return 12'((thr < 4095) ? thr + $urandom_range(0, 1) : thr);
		endcase
	endfunction

	// tick of a walk: encoder average aimed just past (or not past) the last cell count
	function automatic tick_t walk_tick(logic [1:0] hdg, bit advance);
		tick_t  t;
		longint lo;
		longint hi;
		longint avg;
		longint total;
		longint el_lo;
		longint el_hi;
		longint el;
		if (advance && cell_len != 0 && longint'(cells_done + 1) * cell_len <= 65535) begin
			lo = longint'(cells_done + $urandom_range(1, 2)) * cell_len;
			if (lo > 65535)
				lo = longint'(cells_done + 1) * cell_len;
			hi = lo + cell_len - 1;
		end else begin
			lo = 0;
			hi = (cell_len == 0) ? 65535 : longint'(cells_done + 1) * cell_len - 1;
		end
		if (hi > 65535)
			hi = 65535;
		avg = $urandom_range(int'(lo), int'(hi));
		total = 2 * avg + ((avg < 65535) ? $urandom_range(0, 1) : 0);
		el_lo = (total > 65535) ? total - 65535 : 0;
		el_hi = (total < 65535) ? total : 65535;
		el = $urandom_range(int'(el_lo), int'(el_hi));
		t.enc_left = 16'(el);
		t.enc_right = 16'(total - el);
		t.sens_left_front = reading_near(front_thr);
		t.sens_right_front = reading_near(front_thr);
		t.sens_right_side = reading_near(right_thr);
		t.sens_left_side = reading_near(left_thr);
		t.heading = hdg;
		return t;
	endfunction

	function automatic tick_t noise_tick();
		return mk_tick($urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 4095), $urandom_range(0, 4095), 2'($urandom_range(0, 3)));
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// One input transfer. Valid is left high; the caller lowers it for a gap,
	// so back-to-back ticks never see valid dropped and raised in one step.
	task automatic send_tick(input tick_t t);
		in_valid <= 1'b1;
		enc_left <= t.enc_left;
		enc_right <= t.enc_right;
		sens_left_front <= t.sens_left_front;
		sens_right_front <= t.sens_right_front;
		sens_right_side <= t.sens_right_side;
		sens_left_side <= t.sens_left_side;
		heading <= t.heading;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		track_mouse(t);
	endtask

	task automatic sender_gap();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// sender quiet until every predicted report has been seen, then the block settles
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (predicted_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// writes all four registers back to back; only called while idle
	task automatic write_config(input int len, input int f_thr, input int r_thr,
			input int l_thr);
		logic [CfgIdxW-1:0]  regs [4];
		logic [CfgDataW-1:0] vals [4];
		regs = '{CFG_CELL_LENGTH, CFG_FRONT_THRESH, CFG_RIGHT_THRESH, CFG_LEFT_THRESH};
		vals = '{16'(len), 16'(f_thr), 16'(r_thr), 16'(l_thr)};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			case (regs[i])
				CFG_CELL_LENGTH: cell_len = int'(vals[i]);
				CFG_FRONT_THRESH: front_thr = int'(vals[i][11:0]);
				CFG_RIGHT_THRESH: right_thr = int'(vals[i][11:0]);
				default: left_thr = int'(vals[i][11:0]);
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stall bursts, or one long hold on request
	// ------------------------------------------------------------------
	initial begin
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every output transfer against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cell_report_t exp_rep;
		if (out_valid && !out_stall) begin
			if (predicted_reports.size() == 0) begin
				$error("result transfer with no tick outstanding: move %0d cell (%0d,%0d)",
					move, cell_x, cell_y);
				mismatches++;
			end else begin
				exp_rep = predicted_reports.pop_front();
				if (move !== exp_rep.move) begin
					$error("move: expected %0d, actual %0d", exp_rep.move, move);
					mismatches++;
				end
				if (cell_x !== exp_rep.cell_x) begin
					$error("cell_x: expected %0d, actual %0d", exp_rep.cell_x, cell_x);
					mismatches++;
				end
				if (cell_y !== exp_rep.cell_y) begin
					$error("cell_y: expected %0d, actual %0d", exp_rep.cell_y, cell_y);
					mismatches++;
				end
				if (cell_walls !== exp_rep.cell_walls) begin
					$error("cell_walls: expected %h, actual %h", exp_rep.cell_walls,
						cell_walls);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Hand-picked ticks: maze edges, missing neighbors, readings exactly at
	// threshold, one front sensor only, count below last, encoder extremes,
	// zero cell length, all four moves and headings.
	task automatic test_directed();
		// reset config: cell 1000, thresholds 2000
		send_tick(mk_tick(0, 0, 0, 0, 0, 0, DIR_N));
		// step south at y=0 stays put; south and west walls have no neighbor
		send_tick(mk_tick(1000, 1000, 4095, 4095, 4095, 4095, DIR_S));
		// step west at x=0 stays put; readings at threshold are not walls
		send_tick(mk_tick(2000, 2001, 2000, 2000, 2000, 2000, DIR_W));
		// into (0,1); one front sensor above is not a front wall
		send_tick(mk_tick(3000, 3000, 2001, 0, 2001, 0, DIR_N));
		// count drops below last: no step
		send_tick(mk_tick(2500, 2500, 2001, 2001, 4095, 0, DIR_E));
		send_tick(mk_tick(4000, 4000, 0, 0, 0, 0, DIR_S));
		// encoder maximum
		send_tick(mk_tick(65535, 65535, 4095, 0, 0, 4095, DIR_E));
		send_tick(mk_tick(65535, 65534, 0, 4095, 4095, 0, DIR_N));
		wait_idle();

		// zero cell length never steps; zero thresholds make any nonzero reading a wall
		write_config(0, 0, 0, 0);
		send_tick(mk_tick(65535, 65535, 1, 1, 1, 1, DIR_W));
		send_tick(mk_tick(12345, 54321, 0, 0, 0, 0, DIR_E));
		wait_idle();

		// shortest cell, thresholds at maximum: never a wall
		write_config(1, 4095, 4095, 4095);
		send_tick(mk_tick(100, 100, 4095, 4095, 4095, 4095, DIR_N));
		send_tick(mk_tick(150, 151, 4095, 4095, 4095, 4095, DIR_W));
		wait_idle();

		// longest cell: count at most 1, below last
		write_config(65535, 2000, 1000, 3000);
		send_tick(mk_tick(65535, 65535, 4095, 4095, 1500, 4095, DIR_W));
		send_tick(mk_tick(0, 65535, 2001, 2001, 999, 3001, DIR_S));
		wait_idle();
	endtask

	// Random walk: legs of one heading, mostly ticks whose cell count rises by
	// one or two, some that hold, a few of pure noise. Cell length is kept small
	// enough that the count has room to rise by at least 200 more cells.
	task automatic test_random_walk(input int n_ticks, input int f_thr, input int r_thr,
			input int l_thr);
		int         cap;
		int         leg;
		int         sent;
		logic [1:0] hdg;
		tick_t      t;
		wait_idle();
		cap = 65535 / (cells_done + 200);
		if (cap < 1)
			cap = 1;
		write_config($urandom_range(1, cap), f_thr, r_thr, l_thr);
		sent = 0;
		while (sent < n_ticks) begin
			hdg = 2'($urandom_range(0, 3));
			leg = $urandom_range(1, 16);
			for (int k = 0; k < leg && sent < n_ticks; k++) begin
				if ($urandom_range(0, 7) == 0)
					t = noise_tick();
				else
					t = walk_tick(hdg, $urandom_range(0, 3) != 0);
				send_tick(t);
				sender_gap();
				sent++;
			end
		end
	endtask

	// Receiver holds off for a long stretch while ticks keep coming, so the
	// output register and the working tick fill up and the input stalls.
	task automatic test_backpressure();
		wait_idle();
		hold_len = 300;
		for (int k = 0; k < 8; k++)
			send_tick(walk_tick(2'($urandom_range(0, 3)), 1'b1));
		wait_idle();
	endtask

	// closing stretch with no gaps and no stalls
	task automatic test_quiet_finish(input int n_ticks);
		wait_idle();
		idle_on = 1'b0;
		for (int k = 0; k < n_ticks; k++)
			send_tick(walk_tick(2'($urandom_range(0, 3)), $urandom_range(0, 3) != 0));
		wait_idle();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_walk(110, 0, 0, 0);
		test_random_walk(110, 4095, 4095, 4095);
		test_random_walk(110, $urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 4095));
		test_backpressure();
		test_random_walk(110, $urandom_range(1500, 2500), $urandom_range(1500, 2500),
			$urandom_range(1500, 2500));
		test_random_walk(110, $urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 4095));
		test_quiet_finish(180);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
